### hw/rtl/midi_note_message_sequencer_defines.svh
// Assertion macros for the MIDI note message sequencer.
// Included by RTL files that carry assertions; needs a clock i_clk and reset i_rst_n in scope.
`ifndef MIDI_NOTE_MESSAGE_SEQUENCER_DEFINES_SVH
`define MIDI_NOTE_MESSAGE_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define MNMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define MNMS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define MNMS_ASSERT(lbl, prop, msg)
`define MNMS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hw/rtl/mnms_pkg.sv
// Types and constants of the MIDI note message sequencer.
// No dependencies.
`default_nettype none

package mnms_pkg;

    localparam int SLOT_MAX_DEF = 7;
    localparam int CC_REGS      = 7;
    localparam int NUM_CHANNELS = 16;

    // Status nibbles of the channel voice messages.
    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_CTRL     = 4'hB;

    localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;
    localparam logic [6:0] DATA_MAX         = 7'd127;

    // Register map, index = byte address / 4.
    localparam logic [2:0] REG_SLOT_COUNT = 3'd0;
    localparam logic [2:0] REG_CC_BASE    = 3'd1;

    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_KILL     = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OFF_PREV,
        PH_CC,
        PH_NOTE_ON,
        PH_NOTE_OFF,
        PH_KILL
    } t_phase;

    typedef struct packed {
        logic [3:0] status_hi;
        logic [3:0] chan;
        logic [6:0] data_first;
        logic [6:0] data_second;
        logic       last;
    } t_msg;

endpackage

`default_nettype wire

### hw/rtl/midi_note_message_sequencer.sv
// MIDI note message sequencer: turns note events into three-byte channel voice messages.
// Depends on mnms_pkg and midi_note_message_sequencer_defines.svh.
//
//   channel  | direction | handshake          | moves
//   ---------+-----------+--------------------+---------------------------------------
//   event    | in        | i_valid / o_ready  | command, note, velocity, channel, cc values
//   message  | out       | o_valid / i_ready  | status byte, two data bytes, last flag
//   config   | in/out    | APB, pready high   | slot count, seven controller numbers
//
// One shared message former is stepped by a phase sequencer and a four-bit counter, one
// message per cycle while the output does not stall: an accepted event sends up to nine
// messages for a note-on and sixteen for kill.
// o_ready is high only while the sequencer is idle; the output register lets the next
// event be accepted while the last message still waits for its transfer.
// Reset is synchronous and clears the configuration, sequencer, voice and output-valid registers; no clearing pass.
`default_nettype none
`include "midi_note_message_sequencer_defines.svh"

module midi_note_message_sequencer
    import mnms_pkg::*;
#(
    parameter int SLOT_MAX = SLOT_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // event channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [6:0]  i_note,
    input  wire logic [7:0]  i_velocity,
    input  wire logic [3:0]  i_channel,
    input  wire logic [7:0]  i_cc_value_0,
    input  wire logic [7:0]  i_cc_value_1,
    input  wire logic [7:0]  i_cc_value_2,
    input  wire logic [7:0]  i_cc_value_3,
    input  wire logic [7:0]  i_cc_value_4,
    input  wire logic [7:0]  i_cc_value_5,
    input  wire logic [7:0]  i_cc_value_6,
    // message channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_status_byte,
    output logic [6:0]       o_data_first,
    output logic [6:0]       o_data_second,
    output logic             o_last_message,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SLOT_IW = (SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1;
    localparam logic [2:0] SLOT_SAT  = 3'(SLOT_MAX);
    localparam logic [3:0] KILL_LAST = 4'(NUM_CHANNELS - 1);

    // Configuration registers.
    logic [2:0] r_slot_count;
    logic [6:0] r_cc_num [SLOT_MAX];

    // Event held for the sequencer.
    logic [6:0] r_note;
    logic [6:0] r_vel;
    logic [3:0] r_chan;
    logic [6:0] r_ccv [SLOT_MAX];
    logic [2:0] r_slot_n;

    // Voice state.
    logic [6:0] r_held_note;
    logic [3:0] r_held_chan;
    logic       r_sounding;

    t_phase     r_phase, n_phase;
    logic [3:0] r_idx, n_idx;

    logic       r_out_valid;
    t_msg       r_out;

    logic       accept;
    logic       emit;
    logic       cfg_we;
    logic [2:0] cfg_idx;
    logic [6:0] in_ccv [CC_REGS];
    logic [2:0] slot_n;
    logic [2:0] idx_next3;
    t_msg       msg;

    assign in_ccv[0] = i_cc_value_0[7:1];
    assign in_ccv[1] = i_cc_value_1[7:1];
    assign in_ccv[2] = i_cc_value_2[7:1];
    assign in_ccv[3] = i_cc_value_3[7:1];
    assign in_ccv[4] = i_cc_value_4[7:1];
    assign in_ccv[5] = i_cc_value_5[7:1];
    assign in_ccv[6] = i_cc_value_6[7:1];

    assign o_ready   = (r_phase == PH_IDLE);
    assign accept    = i_valid && o_ready;
    assign emit      = (r_phase != PH_IDLE) && (!r_out_valid || i_ready);
    assign slot_n    = (r_slot_count > SLOT_SAT) ? SLOT_SAT : r_slot_count;
    assign idx_next3 = r_idx[2:0] + 3'd1;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= '0;
            for (int k = 0; k < SLOT_MAX; k++) begin
                r_cc_num[k] <= '0;
            end
        end else if (cfg_we) begin
            if (cfg_idx == REG_SLOT_COUNT) begin
                r_slot_count <= pwdata[2:0];
            end
            for (int k = 0; k < SLOT_MAX; k++) begin
                if (cfg_idx == REG_CC_BASE + 3'(k)) begin
                    r_cc_num[k] <= pwdata[6:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_idx == REG_SLOT_COUNT) begin
            prdata = {29'd0, r_slot_count};
        end
        for (int k = 0; k < SLOT_MAX; k++) begin
            if (cfg_idx == REG_CC_BASE + 3'(k)) begin
                prdata = {25'd0, r_cc_num[k]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Event capture.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_note   <= i_note;
            r_vel    <= i_velocity[7] ? DATA_MAX : i_velocity[6:0];
            r_chan   <= i_channel;
            r_slot_n <= slot_n;
            for (int k = 0; k < SLOT_MAX; k++) begin
                r_ccv[k] <= in_ccv[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared message former: builds the message of the current step.
    // ------------------------------------------------------------------
    always_comb begin
        msg = '0;
        case (r_phase)
            PH_OFF_PREV: begin
                msg.status_hi  = ST_NOTE_OFF;
                msg.chan       = r_held_chan;
                msg.data_first = r_held_note;
            end
            PH_CC: begin
                msg.status_hi   = ST_CTRL;
                msg.chan        = r_chan;
                msg.data_first  = r_cc_num[r_idx[SLOT_IW-1:0]];
                msg.data_second = r_ccv[r_idx[SLOT_IW-1:0]];
            end
            PH_NOTE_ON: begin
                msg.status_hi   = ST_NOTE_ON;
                msg.chan        = r_chan;
                msg.data_first  = r_note;
                msg.data_second = r_vel;
                msg.last        = 1'b1;
            end
            PH_NOTE_OFF: begin
                msg.status_hi  = ST_NOTE_OFF;
                msg.chan       = r_held_chan;
                msg.data_first = r_note;
                msg.last       = 1'b1;
            end
            PH_KILL: begin
                msg.status_hi  = ST_CTRL;
                msg.chan       = r_idx;
                msg.data_first = CC_ALL_NOTES_OFF;
                msg.last       = (r_idx == KILL_LAST);
            end
            default: begin
                msg = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        case (r_phase)
            PH_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    case (i_command)
                        CMD_NOTE_ON: begin
                            if (r_sounding) begin
                                n_phase = PH_OFF_PREV;
                            end else if (slot_n != 3'd0) begin
                                n_phase = PH_CC;
                            end else begin
                                n_phase = PH_NOTE_ON;
                            end
                        end
                        CMD_NOTE_OFF: begin
                            n_phase = r_sounding ? PH_NOTE_OFF : PH_IDLE;
                        end
                        CMD_KILL: begin
                            n_phase = PH_KILL;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            PH_OFF_PREV: begin
                if (emit) begin
                    n_phase = (r_slot_n != 3'd0) ? PH_CC : PH_NOTE_ON;
                end
            end
            PH_CC: begin
                if (emit) begin
                    if (idx_next3 == r_slot_n) begin
                        n_phase = PH_NOTE_ON;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            PH_NOTE_ON, PH_NOTE_OFF: begin
                if (emit) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_KILL: begin
                if (emit) begin
                    n_idx = r_idx + 4'd1;
                    if (r_idx == KILL_LAST) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_idx   = '0;
            end
        endcase
    end

    // Voice state: a note-off or kill settles at accept, a note-on when it is sent.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_note <= '0;
            r_held_chan <= '0;
            r_sounding  <= 1'b0;
        end else if (accept && i_command == CMD_NOTE_OFF) begin
            if (r_sounding && i_note == r_held_note) begin
                r_sounding <= 1'b0;
            end
        end else if (accept && i_command == CMD_KILL) begin
            r_sounding <= 1'b0;
        end else if (emit && r_phase == PH_NOTE_ON) begin
            r_held_note <= r_note;
            r_held_chan <= r_chan;
            r_sounding  <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= msg;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status_byte  = {r_out.status_hi, r_out.chan};
    assign o_data_first   = r_out.data_first;
    assign o_data_second  = r_out.data_second;
    assign o_last_message = r_out.last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `MNMS_ASSERT(a_cc_idx_in_range, (r_phase == PH_CC) |-> (r_idx[2:0] < r_slot_n), "slot index past slot count")
    `MNMS_ASSERT(a_off_prev_needs_note, (r_phase == PH_OFF_PREV) |-> r_sounding, "previous note-off without a sounding note")
    `MNMS_ASSERT(a_note_on_records, (emit && r_phase == PH_NOTE_ON) |=> (r_sounding && r_phase == PH_IDLE), "note-on did not record the note")
    `MNMS_ASSERT(a_note_on_is_last, (o_valid && o_status_byte[7:4] == ST_NOTE_ON) |-> o_last_message, "note-on not marked as last message")
    `MNMS_ASSERT_ALWAYS(a_reset_idle, (!i_rst_n) |=> (r_phase == PH_IDLE && !r_out_valid), "sequencer not idle after reset")

endmodule

`default_nettype wire
